// ===== hdl/ordered_list_insert_delete_defines.svh =====
// Assertion macros shared by the ordered list block.
// Needs a clock named clk and an active low reset named arst_n in scope.
`ifndef ORDERED_LIST_INSERT_DELETE_DEFINES_SVH
`define ORDERED_LIST_INSERT_DELETE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OLI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define OLI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/oli_pkg.sv =====
// Shared constants for the ordered list block: sizes, operation kinds and status codes.
// No dependencies.
package oli_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int LEN_W    = $clog2(CAPACITY + 1);

	localparam int KIND_W   = 3;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	localparam logic [KIND_W-1:0] K_APPEND    = 3'd0;
	localparam logic [KIND_W-1:0] K_DEL_FIRST = 3'd1;
	localparam logic [KIND_W-1:0] K_DEL_LAST  = 3'd2;
	localparam logic [KIND_W-1:0] K_DEL_POS   = 3'd3;
	localparam logic [KIND_W-1:0] K_DISPLAY   = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

endpackage

// ===== hdl/oli_if.sv =====
// Request and result channel interfaces of the ordered list block.
// Depends on oli_pkg for field widths.
interface oli_req_if;
	logic                              valid;
	logic                              ready;
	logic [oli_pkg::KIND_W-1:0]        kind;
	logic signed [oli_pkg::DATA_W-1:0] value;
	logic [oli_pkg::POS_W-1:0]         position;

	modport source (output valid, output kind, output value, output position, input ready);
	modport sink   (input valid, input kind, input value, input position, output ready);
endinterface

interface oli_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [oli_pkg::STATUS_W-1:0]      status;
	logic signed [oli_pkg::DATA_W-1:0] element;
	logic [oli_pkg::COUNT_W-1:0]       count;
	logic                              last;

	modport source (output valid, output status, output element, output count, output last,
		input ready);
	modport sink   (input valid, input status, input element, input count, input last,
		output ready);
endinterface

// ===== hdl/oli_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module oli_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/ordered_list_insert_delete.sv =====
// Ordered list of signed words. Append, delete last and rejected requests finish in idle.
// Delete first or at a position moves each later element down through the RAM, one per
// cycle, then returns the new count. Display streams one element per cycle through a
// registered RAM read, as long as the result channel takes each beat.
// A request is taken only in idle and only when the result register is empty or its beat
// leaves in the same cycle. Reset empties the list; the RAM contents are not cleared.
module ordered_list_insert_delete (
	input  logic      clk,
	input  logic      arst_n,
	oli_req_if.sink   req,
	oli_rsp_if.source rsp
);
	import oli_pkg::*;

	`include "ordered_list_insert_delete_defines.svh"

	typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_DISP} state_t;

	state_t                state_q;
	logic [LEN_W-1:0]      len_q;
	logic [LEN_W-1:0]      rd_q;
	logic                  dv_s1;
	logic [IDX_W-1:0]      wa_s1;

	logic                  out_v_q;
	logic [STATUS_W-1:0]   status_q;
	logic [DATA_W-1:0]     element_q;
	logic [COUNT_W-1:0]    count_q;
	logic                  last_q;

	logic                  slot_free;
	logic                  accept;
	logic                  empty;
	logic                  full;
	logic                  pos_bad;
	logic                  more;

	logic                  emit;
	logic [STATUS_W-1:0]   e_status;
	logic [DATA_W-1:0]     e_elem;
	logic [COUNT_W-1:0]    e_count;
	logic                  e_last;

	logic                  we;
	logic [IDX_W-1:0]      waddr;
	logic [DATA_W-1:0]     wdata;
	logic                  re;
	logic [DATA_W-1:0]     rdata;

	oli_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (DATA_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (rd_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	assign slot_free = !out_v_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && slot_free;
	assign accept    = req.valid && req.ready;

	assign empty   = (len_q == '0);
	assign full    = (len_q >= LEN_W'(CAPACITY));
	assign pos_bad = (req.position == '0) || (req.position > POS_W'(len_q));
	assign more    = (rd_q < len_q);

	always_comb begin
		emit     = 1'b0;
		e_status = ST_OK;
		e_elem   = '0;
		e_count  = COUNT_W'(len_q);
		e_last   = 1'b1;
		we       = 1'b0;
		waddr    = wa_s1;
		wdata    = rdata;
		re       = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.kind)
						K_APPEND: begin
							emit = 1'b1;
							if (full) begin
								e_status = ST_FULL;
							end else begin
								we      = 1'b1;
								waddr   = len_q[IDX_W-1:0];
								wdata   = req.value;
								e_count = COUNT_W'(len_q + 1'b1);
							end
						end
						K_DEL_FIRST: begin
							if (empty) begin
								emit     = 1'b1;
								e_status = ST_EMPTY;
							end
						end
						K_DEL_LAST: begin
							emit = 1'b1;
							if (empty) begin
								e_status = ST_EMPTY;
							end else begin
								e_count = COUNT_W'(len_q - 1'b1);
							end
						end
						K_DEL_POS: begin
							if (empty) begin
								emit     = 1'b1;
								e_status = ST_EMPTY;
							end else if (pos_bad) begin
								emit     = 1'b1;
								e_status = ST_INVALID;
							end
						end
						K_DISPLAY: begin
							if (empty) begin
								emit     = 1'b1;
								e_status = ST_EMPTY;
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			S_SHIFT: begin
				// Read entry i+1 now, write it to entry i in the next cycle.
				we = dv_s1;
				re = more;
				if (!dv_s1 && !more && slot_free) begin
					emit    = 1'b1;
					e_count = COUNT_W'(len_q - 1'b1);
				end
			end
			S_DISP: begin
				re = more && (!dv_s1 || slot_free);
				if (dv_s1 && slot_free) begin
					emit   = 1'b1;
					e_elem = rdata;
					e_last = !more;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			rd_q    <= '0;
			dv_s1   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (emit) begin
				out_v_q   <= 1'b1;
				status_q  <= e_status;
				element_q <= e_elem;
				count_q   <= e_count;
				last_q    <= e_last;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end

			dv_s1 <= re || (dv_s1 && (state_q == S_DISP) && !slot_free);
			if (re) begin
				rd_q  <= rd_q + 1'b1;
				wa_s1 <= IDX_W'(rd_q - 1'b1);
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.kind)
							K_APPEND: begin
								if (!full) begin
									len_q <= len_q + 1'b1;
								end
							end
							K_DEL_FIRST: begin
								if (!empty) begin
									rd_q    <= LEN_W'(1);
									state_q <= S_SHIFT;
								end
							end
							K_DEL_LAST: begin
								if (!empty) begin
									len_q <= len_q - 1'b1;
								end
							end
							K_DEL_POS: begin
								if (!empty && !pos_bad) begin
									rd_q    <= req.position[LEN_W-1:0];
									state_q <= S_SHIFT;
								end
							end
							K_DISPLAY: begin
								if (!empty) begin
									rd_q    <= '0;
									state_q <= S_DISP;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SHIFT: begin
					if (emit) begin
						len_q   <= len_q - 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DISP: begin
					if (emit && e_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid   = out_v_q;
	assign rsp.status  = status_q;
	assign rsp.element = element_q;
	assign rsp.count   = count_q;
	assign rsp.last    = last_q;

	`OLI_ASSERT_NOW(a_len_cap, 1'b1, len_q <= LEN_W'(CAPACITY), "list length above capacity")
	`OLI_ASSERT_NOW(a_ram_no_clash, we && re, waddr != rd_q[IDX_W-1:0], "RAM read and write collide")
	`OLI_ASSERT_NEXT(a_append_len, accept && (req.kind == K_APPEND) && !full,
		len_q == LEN_W'($past(len_q) + 1'b1), "append did not grow the list")
	`OLI_ASSERT_NOW(a_emit_slot, emit, slot_free, "result overwrites an untaken beat")

endmodule
